// File: src/mlrq_pkg.sv
// ---------------------------------------------------------------------------
// mlrq_pkg: shared types and codes of the multilevel ready-queue scheduler
// Item modes, result kinds, sequencer states and the structs passed
// between the sequencer, the time compare unit and the top level.
// ---------------------------------------------------------------------------
package mlrq_pkg;

    localparam int ID_W   = 16;
    localparam int LVL_W  = 3;
    localparam int TIME_W = 32;

    localparam logic [2:0] MODE_ADD_READY   = 3'd0;
    localparam logic [2:0] MODE_ADD_PENDING = 3'd1;
    localparam logic [2:0] MODE_TICK        = 3'd2;
    localparam logic [2:0] MODE_GET_NEXT    = 3'd3;
    localparam logic [2:0] MODE_DEMOTE      = 3'd4;

    localparam logic [2:0] KIND_ACCEPTED  = 3'd0;
    localparam logic [2:0] KIND_REJECTED  = 3'd1;
    localparam logic [2:0] KIND_DISPATCH  = 3'd2;
    localparam logic [2:0] KIND_NONE      = 3'd3;
    localparam logic [2:0] KIND_ARRIVED   = 3'd4;
    localparam logic [2:0] KIND_TIMED_OUT = 3'd5;
    localparam logic [2:0] KIND_DEMOTED   = 3'd6;
    localparam logic [2:0] KIND_TICK_DONE = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ADD_WR,
        ST_ADD_LINK,
        ST_TICK_LIST,
        ST_TICK_ADV,
        ST_WALK_RD,
        ST_WALK_EV,
        ST_MOVE_CLR,
        ST_MOVE_LINK,
        ST_GN_RD,
        ST_GN_EV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [2:0]        kind;
        logic [ID_W-1:0]   task_id;
        logic [LVL_W-1:0]  level;
        logic              last;
        logic              all_empty;
    } t_result;

    typedef struct packed {
        logic [TIME_W-1:0] slot_time;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] limit;
    } t_cmp_in;

    typedef struct packed {
        logic due;
        logic expired;
    } t_cmp_out;

endpackage

// File: src/mlrq_cmp.sv
// ---------------------------------------------------------------------------
// mlrq_cmp: shared time compare unit
// One subtract and compare: due when slot time is not after now, expired
// when the elapsed wait reaches the limit (a zero limit counts as one).
// ---------------------------------------------------------------------------
module mlrq_cmp (
    input  mlrq_pkg::t_cmp_in  i_cmp,
    output mlrq_pkg::t_cmp_out o_cmp
);

    logic [mlrq_pkg::TIME_W-1:0] w_diff;
    logic [mlrq_pkg::TIME_W-1:0] w_lim;

    assign w_diff = i_cmp.now - i_cmp.slot_time;
    assign w_lim  = (i_cmp.limit == '0) ? mlrq_pkg::TIME_W'(1) : i_cmp.limit;

    assign o_cmp.due     = (i_cmp.slot_time <= i_cmp.now);
    assign o_cmp.expired = (i_cmp.slot_time <= i_cmp.now) && (w_diff >= w_lim);

endmodule

// File: src/mlrq_core.sv
// ---------------------------------------------------------------------------
// mlrq_core: list sequencer and slot table
// Walks the linked lists one slot at a time through a single read port,
// one result transaction per emit step.
// ---------------------------------------------------------------------------
module mlrq_core #(
    parameter int LEVELS     = 4,
    parameter int TASK_SLOTS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [2:0]                    i_mode,
    input  logic [mlrq_pkg::ID_W-1:0]     i_task_id,
    input  logic [mlrq_pkg::LVL_W-1:0]    i_pr,
    input  logic [mlrq_pkg::TIME_W-1:0]   i_arr,
    input  logic [mlrq_pkg::TIME_W-1:0]   i_now,
    input  logic [mlrq_pkg::TIME_W-1:0]   i_timeout,
    input  logic                          i_out_free,
    output logic                          o_push,
    output mlrq_pkg::t_result             o_res
);

    localparam int SW = $clog2(TASK_SLOTS);
    localparam int CW = $clog2(TASK_SLOTS + 1);
    localparam int LW = $clog2(LEVELS + 1);
    localparam logic [LW-1:0] PEND = LW'(LEVELS);

    mlrq_pkg::t_state r_state, n_state, r_ret;

    // slot table
    logic [mlrq_pkg::ID_W-1:0]   m_id   [TASK_SLOTS];
    logic [mlrq_pkg::TIME_W-1:0] m_time [TASK_SLOTS];
    logic [mlrq_pkg::LVL_W-1:0]  m_lvl  [TASK_SLOTS];
    logic [SW-1:0]               m_link [TASK_SLOTS];
    logic [TASK_SLOTS-1:0]       r_in_use;

    logic [mlrq_pkg::ID_W-1:0]   r_rd_id;
    logic [mlrq_pkg::TIME_W-1:0] r_rd_time;
    logic [mlrq_pkg::LVL_W-1:0]  r_rd_lvl;
    logic [SW-1:0]               r_rd_link;

    // lists: 0..LEVELS-1 ready queues, LEVELS the pending list
    logic [SW-1:0] r_head [LEVELS+1];
    logic [SW-1:0] r_tail [LEVELS+1];
    logic [CW-1:0] r_cnt  [LEVELS+1];

    logic [2:0]                  r_mode;
    logic [mlrq_pkg::ID_W-1:0]   r_id;
    logic [mlrq_pkg::LVL_W-1:0]  r_pr;
    logic [mlrq_pkg::TIME_W-1:0] r_arr;
    logic [mlrq_pkg::TIME_W-1:0] r_now;
    logic [mlrq_pkg::TIME_W-1:0] r_time_now;
    logic [SW-1:0]               r_scan;
    logic [SW-1:0]               r_slot;
    logic [SW-1:0]               r_cur;
    logic [SW-1:0]               r_prev;
    logic                        r_has_prev;
    logic [CW-1:0]               r_left;
    logic [LW-1:0]               r_list;
    logic [LW-1:0]               r_mv;
    mlrq_pkg::t_result           r_res;

    // combinational control
    logic                        w_bad_pr;
    logic                        w_any;
    logic [LW-1:0]               w_first;
    logic                        w_empty;
    logic                        w_hit;
    logic [LW-1:0]               w_add_list;
    logic [LW-1:0]               w_clamp;
    logic [mlrq_pkg::LVL_W-1:0]  w_dem_lvl;
    logic [SW-1:0]               w_rd_addr;
    logic                        w_link_we;
    logic [SW-1:0]               w_link_addr;
    logic [SW-1:0]               w_link_data;
    logic                        w_time_we;
    logic [mlrq_pkg::TIME_W-1:0] w_time_data;
    mlrq_pkg::t_cmp_in           w_cmp_in;
    mlrq_pkg::t_cmp_out          w_cmp_out;

    mlrq_cmp u_cmp (
        .i_cmp (w_cmp_in),
        .o_cmp (w_cmp_out)
    );

    assign w_cmp_in.slot_time = r_rd_time;
    assign w_cmp_in.now       = r_now;
    assign w_cmp_in.limit     = i_timeout;

    assign w_bad_pr   = ({1'b0, i_pr} >= 4'(LEVELS));
    assign w_add_list = (r_mode == mlrq_pkg::MODE_ADD_PENDING) ? PEND : LW'(r_pr);
    assign w_clamp    = ({1'b0, r_rd_lvl} >= 4'(LEVELS)) ? LW'(LEVELS - 1) : LW'(r_rd_lvl);
    assign w_hit      = (r_list == PEND) ? w_cmp_out.due : w_cmp_out.expired;
    // demotion saturates at the last level; level 0 stays put
    assign w_dem_lvl  = (i_pr != '0 && {1'b0, i_pr} < 4'(LEVELS - 1)) ? i_pr + 3'd1 : i_pr;

    always_comb begin
        w_any   = 1'b0;
        w_first = '0;
        w_empty = 1'b1;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (r_cnt[l] != '0) begin
                w_any   = 1'b1;
                w_first = LW'(l);
            end
        end
        for (int l = 0; l <= LEVELS; l++) begin
            if (r_cnt[l] != '0) begin
                w_empty = 1'b0;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mlrq_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_mode)
                        mlrq_pkg::MODE_ADD_READY,
                        mlrq_pkg::MODE_ADD_PENDING:
                            n_state = w_bad_pr ? mlrq_pkg::ST_EMIT : mlrq_pkg::ST_SCAN;
                        mlrq_pkg::MODE_TICK:
                            n_state = mlrq_pkg::ST_TICK_LIST;
                        mlrq_pkg::MODE_GET_NEXT:
                            n_state = w_any ? mlrq_pkg::ST_GN_RD : mlrq_pkg::ST_EMIT;
                        default:
                            n_state = mlrq_pkg::ST_EMIT;
                    endcase
                end
            end
            mlrq_pkg::ST_SCAN: begin
                if (!r_in_use[r_scan]) begin
                    n_state = mlrq_pkg::ST_ADD_WR;
                end else if (r_scan == SW'(TASK_SLOTS - 1)) begin
                    n_state = mlrq_pkg::ST_EMIT;
                end
            end
            mlrq_pkg::ST_ADD_WR:    n_state = mlrq_pkg::ST_ADD_LINK;
            mlrq_pkg::ST_ADD_LINK:  n_state = mlrq_pkg::ST_EMIT;
            mlrq_pkg::ST_TICK_LIST:
                n_state = (r_cnt[r_list] == '0) ? mlrq_pkg::ST_TICK_ADV : mlrq_pkg::ST_WALK_RD;
            mlrq_pkg::ST_TICK_ADV:
                n_state = (r_list == LW'(LEVELS - 1)) ? mlrq_pkg::ST_EMIT
                                                       : mlrq_pkg::ST_TICK_LIST;
            mlrq_pkg::ST_WALK_RD:   n_state = mlrq_pkg::ST_WALK_EV;
            mlrq_pkg::ST_WALK_EV: begin
                if (w_hit) begin
                    n_state = (r_list == PEND) ? mlrq_pkg::ST_MOVE_CLR : mlrq_pkg::ST_EMIT;
                end else begin
                    n_state = (r_left == CW'(1)) ? mlrq_pkg::ST_TICK_ADV : mlrq_pkg::ST_WALK_RD;
                end
            end
            mlrq_pkg::ST_MOVE_CLR:  n_state = mlrq_pkg::ST_MOVE_LINK;
            mlrq_pkg::ST_MOVE_LINK: n_state = mlrq_pkg::ST_EMIT;
            mlrq_pkg::ST_GN_RD:     n_state = mlrq_pkg::ST_GN_EV;
            mlrq_pkg::ST_GN_EV:     n_state = mlrq_pkg::ST_EMIT;
            mlrq_pkg::ST_EMIT:      n_state = i_out_free ? r_ret : mlrq_pkg::ST_EMIT;
            default:                n_state = mlrq_pkg::ST_IDLE;
        endcase
    end

    // outputs and table port controls
    always_comb begin
        o_in_ready  = (r_state == mlrq_pkg::ST_IDLE);
        o_push      = (r_state == mlrq_pkg::ST_EMIT) && i_out_free;
        o_res       = r_res;
        o_res.all_empty = w_empty;
        w_rd_addr   = r_cur;
        w_link_we   = 1'b0;
        w_link_addr = r_slot;
        w_link_data = '0;
        w_time_we   = 1'b0;
        w_time_data = r_now;
        case (r_state)
            mlrq_pkg::ST_ADD_WR: begin
                w_link_we   = 1'b1;
                w_time_we   = 1'b1;
                w_time_data = (r_mode == mlrq_pkg::MODE_ADD_PENDING) ? r_arr : r_time_now;
            end
            mlrq_pkg::ST_ADD_LINK: begin
                w_link_we   = (r_cnt[w_add_list] != '0);
                w_link_addr = r_tail[w_add_list];
                w_link_data = r_slot;
            end
            mlrq_pkg::ST_WALK_EV: begin
                w_link_we   = w_hit && r_has_prev;
                w_link_addr = r_prev;
                w_link_data = r_rd_link;
                w_time_we   = w_hit && (r_list == PEND);
                w_time_data = r_now;
            end
            mlrq_pkg::ST_MOVE_CLR: begin
                w_link_we   = 1'b1;
            end
            mlrq_pkg::ST_MOVE_LINK: begin
                w_link_we   = (r_cnt[r_mv] != '0);
                w_link_addr = r_tail[r_mv];
                w_link_data = r_slot;
            end
            mlrq_pkg::ST_GN_RD: begin
                w_rd_addr   = r_head[r_list];
            end
            default: ;
        endcase
    end

    // slot table port: one registered read, writes per field
    always_ff @(posedge i_clk) begin
        r_rd_id   <= m_id[w_rd_addr];
        r_rd_time <= m_time[w_rd_addr];
        r_rd_lvl  <= m_lvl[w_rd_addr];
        r_rd_link <= m_link[w_rd_addr];
        if (r_state == mlrq_pkg::ST_ADD_WR) begin
            m_id[r_slot]  <= r_id;
            m_lvl[r_slot] <= r_pr;
        end
        if (w_link_we) begin
            m_link[w_link_addr] <= w_link_data;
        end
        if (w_time_we) begin
            m_time[(r_state == mlrq_pkg::ST_WALK_EV) ? r_cur : r_slot] <= w_time_data;
        end
    end

    // payload held for the item in flight
    always_ff @(posedge i_clk) begin
        case (r_state)
            mlrq_pkg::ST_IDLE: begin
                r_mode <= i_mode;
                r_id   <= i_task_id;
                r_pr   <= i_pr;
                r_arr  <= i_arr;
                r_now  <= i_now;
                r_scan <= '0;
                r_list <= (i_mode == mlrq_pkg::MODE_TICK) ? PEND : w_first;
                r_ret  <= mlrq_pkg::ST_IDLE;
                if (i_mode == mlrq_pkg::MODE_GET_NEXT) begin
                    r_res <= '{kind: mlrq_pkg::KIND_NONE, task_id: '0,
                               level: '0, last: 1'b1, all_empty: 1'b0};
                end else if (i_mode == mlrq_pkg::MODE_DEMOTE && !w_bad_pr) begin
                    r_res <= '{kind: mlrq_pkg::KIND_DEMOTED, task_id: i_task_id,
                               level: w_dem_lvl, last: 1'b1, all_empty: 1'b0};
                end else begin
                    r_res <= '{kind: mlrq_pkg::KIND_REJECTED, task_id: i_task_id,
                               level: i_pr, last: 1'b1, all_empty: 1'b0};
                end
            end
            mlrq_pkg::ST_SCAN: begin
                r_slot <= r_scan;
                r_scan <= r_scan + SW'(1);
            end
            mlrq_pkg::ST_ADD_LINK: begin
                r_res.kind <= mlrq_pkg::KIND_ACCEPTED;
            end
            mlrq_pkg::ST_TICK_LIST: begin
                r_cur      <= r_head[r_list];
                r_left     <= r_cnt[r_list];
                r_has_prev <= 1'b0;
            end
            mlrq_pkg::ST_TICK_ADV: begin
                r_list <= (r_list == PEND) ? LW'(1) : r_list + LW'(1);
                r_res  <= '{kind: mlrq_pkg::KIND_TICK_DONE, task_id: '0, level: '0,
                            last: 1'b1, all_empty: 1'b0};
                r_ret  <= mlrq_pkg::ST_IDLE;
            end
            mlrq_pkg::ST_WALK_EV: begin
                r_cur  <= r_rd_link;
                r_left <= r_left - CW'(1);
                r_slot <= r_cur;
                r_mv   <= w_clamp;
                r_ret  <= (r_left == CW'(1)) ? mlrq_pkg::ST_TICK_ADV : mlrq_pkg::ST_WALK_RD;
                r_res.task_id <= r_rd_id;
                r_res.last    <= 1'b0;
                if (r_list == PEND) begin
                    r_res.kind  <= mlrq_pkg::KIND_ARRIVED;
                    r_res.level <= 3'(w_clamp);
                end else begin
                    r_res.kind  <= mlrq_pkg::KIND_TIMED_OUT;
                    r_res.level <= 3'(r_list);
                end
                if (!w_hit) begin
                    r_prev     <= r_cur;
                    r_has_prev <= 1'b1;
                end
            end
            mlrq_pkg::ST_GN_EV: begin
                r_res <= '{kind: mlrq_pkg::KIND_DISPATCH, task_id: r_rd_id,
                           level: 3'(r_list), last: 1'b1, all_empty: 1'b0};
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mlrq_pkg::ST_IDLE;
            r_in_use   <= '0;
            r_time_now <= '0;
            for (int l = 0; l <= LEVELS; l++) begin
                r_head[l] <= '0;
                r_tail[l] <= '0;
                r_cnt[l]  <= '0;
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                mlrq_pkg::ST_IDLE: begin
                    if (i_in_valid && i_mode == mlrq_pkg::MODE_TICK) begin
                        r_time_now <= i_now;
                    end
                end
                mlrq_pkg::ST_ADD_WR: begin
                    r_in_use[r_slot] <= 1'b1;
                end
                mlrq_pkg::ST_ADD_LINK: begin
                    if (r_cnt[w_add_list] == '0) begin
                        r_head[w_add_list] <= r_slot;
                    end
                    r_tail[w_add_list] <= r_slot;
                    r_cnt[w_add_list]  <= r_cnt[w_add_list] + CW'(1);
                end
                mlrq_pkg::ST_WALK_EV: begin
                    if (w_hit) begin
                        r_cnt[r_list] <= r_cnt[r_list] - CW'(1);
                        if (r_cnt[r_list] == CW'(1)) begin
                            r_head[r_list] <= '0;
                            r_tail[r_list] <= '0;
                        end else begin
                            if (!r_has_prev) begin
                                r_head[r_list] <= r_rd_link;
                            end
                            if (r_tail[r_list] == r_cur) begin
                                r_tail[r_list] <= r_has_prev ? r_prev : '0;
                            end
                        end
                        if (r_list != PEND) begin
                            r_in_use[r_cur] <= 1'b0;
                        end
                    end
                end
                mlrq_pkg::ST_MOVE_LINK: begin
                    if (r_cnt[r_mv] == '0) begin
                        r_head[r_mv] <= r_slot;
                    end
                    r_tail[r_mv] <= r_slot;
                    r_cnt[r_mv]  <= r_cnt[r_mv] + CW'(1);
                end
                mlrq_pkg::ST_GN_EV: begin
                    r_in_use[r_head[r_list]] <= 1'b0;
                    r_cnt[r_list]  <= r_cnt[r_list] - CW'(1);
                    if (r_cnt[r_list] == CW'(1)) begin
                        r_head[r_list] <= '0;
                        r_tail[r_list] <= '0;
                    end else begin
                        r_head[r_list] <= r_rd_link;
                        if (r_tail[r_list] == r_head[r_list]) begin
                            r_tail[r_list] <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // a slot is only claimed while free
    a_claim_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mlrq_pkg::ST_ADD_WR) |-> !r_in_use[r_slot])
        else $error("claimed slot already in use");

    // the final result of an item hands control back to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && r_res.last) |=> (r_state == mlrq_pkg::ST_IDLE))
        else $error("final result did not end the item");

    // the pending list never holds more than the table
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[PEND] <= CW'(TASK_SLOTS))
        else $error("pending count beyond table size");

    // a dispatch only comes from a non-empty level
    a_gn_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mlrq_pkg::ST_GN_RD) |-> (r_cnt[r_list] != '0))
        else $error("dispatch from an empty level");

endmodule

// File: src/multilevel_ready_queue_scheduler.sv
// ---------------------------------------------------------------------------
// multilevel_ready_queue_scheduler: multilevel ready-queue task scheduler
// Adds scan the table for a free slot, one slot a cycle, rejected on a full
// table or bad level; get-next dispatches the first non-empty level's head or
// answers none if none is ready; demote and unused modes reply directly. A
// tick walks the pending list, then levels 1 up, slot by slot, with a result
// per timeout and arrival and one for tick done: one slot-table read port. One
// item at a time. Sync active-low reset empties all lists, timeout 20.
// ---------------------------------------------------------------------------
module multilevel_ready_queue_scheduler #(
    parameter int LEVELS     = 4,
    parameter int TASK_SLOTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [87:0] i_s_tdata,  // task_id[15:0] priority_req[18:16]
                                    // due_tick[50:19] now[82:51]
    input  logic [2:0]  i_s_tuser,  // mode[2:0]
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,  // result_task_id[15:0] result_level[18:16]
                                    // all_empty[19]
    output logic [2:0]  o_m_tuser,  // kind[2:0]
    output logic        o_m_tlast,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [31:0] TIMEOUT_RESET = 32'd20;

    logic [31:0]       r_timeout;
    logic              r_m_valid;
    mlrq_pkg::t_result r_m_res;
    logic              w_out_free;
    logic              w_push;
    mlrq_pkg::t_result w_res;

    // timeout register at byte address 0
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? r_timeout : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            r_timeout <= pwdata;
        end
    end

    // output register: free when empty or being taken this cycle
    assign w_out_free = !r_m_valid || i_m_tready;

    mlrq_core #(
        .LEVELS     (LEVELS),
        .TASK_SLOTS (TASK_SLOTS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_mode     (i_s_tuser),
        .i_task_id  (i_s_tdata[15:0]),
        .i_pr       (i_s_tdata[18:16]),
        .i_arr      (i_s_tdata[50:19]),
        .i_now      (i_s_tdata[82:51]),
        .i_timeout  (r_timeout),
        .i_out_free (w_out_free),
        .o_push     (w_push),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_push) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_m_res <= w_res;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {4'd0, r_m_res.all_empty, r_m_res.level, r_m_res.task_id};
    assign o_m_tuser  = r_m_res.kind;
    assign o_m_tlast  = r_m_res.last;

endmodule
